### rtl/assert_macros.svh
// Assertion macros used by the RTL of the LZSS decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a cause in this cycle brings an effect in the next cycle.
`define CHK_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

### rtl/lzsd_pkg.sv
// Types and constants of the LZSS bitstream decoder.
package lzsd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

    // One compressed input word.
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              stream_end;
    } t_in;

    // One decompressed output word.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
    } t_out;

endpackage

### rtl/lzsd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lzsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write at one address, register the read at another.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lzss_bitstream_decoder_core.sv
// LZSS bitstream decoder: bit-serial token parser, history window and copy sequencer.
//
// Accepts one compressed word per handshake and parses its eight bits one per
// cycle while no byte is being emitted, most significant first: a 1 flag takes
// an 8-bit literal, a 0 flag takes an absolute window offset and a length, and a
// match copies length+MATCH_BIAS+1 bytes from the window. Every emitted byte is
// also written to the history window, a WINDOW_SIZE x 8 RAM with registered read.
// An input word passes an accept state and then its bit states; each literal
// adds an output state and each copied byte a window read state, then an
// output state, and the output side can stall any output state. At the
// defaults at most one token ends in a word; narrow token fields let a second
// match end in the same word and add its copy states. run_last marks the final
// byte that a word produces. After a word with stream_end set, the parser,
// write pointer and window return to their start state; the window reads back
// as spaces through a fill count, so no clearing pass is needed and the block is
// ready for the next stream at once.
`include "assert_macros.svh"

module lzss_bitstream_decoder_core #(
    parameter int unsigned WINDOW_SIZE  = 2048,
    parameter int unsigned LOOKAHEAD    = 17,
    parameter int unsigned MATCH_BIAS   = 1,
    parameter int unsigned OFFSET_WIDTH = 11,
    parameter int unsigned LENGTH_WIDTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lzsd_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lzsd_pkg::t_out   o_out_data
);

    import lzsd_pkg::*;

    localparam int unsigned AW     = $clog2(WINDOW_SIZE);
    localparam int unsigned TOK_W  = OFFSET_WIDTH + LENGTH_WIDTH;
    localparam int unsigned TBW    = (TOK_W > BYTE_W) ? TOK_W : BYTE_W;
    localparam int unsigned TCW    = $clog2(TBW + 1);
    localparam int unsigned SW     = (OFFSET_WIDTH > AW) ? OFFSET_WIDTH : AW;
    localparam int unsigned CLW    = LENGTH_WIDTH + 4;
    localparam logic [AW-1:0] WSTART = AW'(WINDOW_SIZE - LOOKAHEAD);
    localparam logic [AW:0]   FILL_FULL = (AW+1)'(WINDOW_SIZE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BITS = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        K_FLAG  = 2'd0,
        K_LIT   = 2'd1,
        K_MATCH = 2'd2
    } t_kind;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_sr, n_sr;
    logic [3:0]        r_left, n_left;
    logic              r_end, n_end;
    t_kind             r_kind, n_kind;
    logic [TBW-1:0]    r_tok, n_tok;
    logic [TCW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW:0]       r_fill, n_fill;
    logic [AW-1:0]     r_src, n_src;
    logic [CLW-1:0]    r_copy, n_copy;
    logic              r_is_copy, n_is_copy;
    logic              r_src_ok, n_src_ok;
    logic [BYTE_W-1:0] r_lit, n_lit;
    logic              r_tail_none, n_tail_none;

    logic                    bit_in;
    logic [3:0]              left_dec;
    logic [TBW-1:0]          tok_sh;
    logic [TCW-1:0]          cnt_inc;
    logic                    tail_more;
    logic [OFFSET_WIDTH-1:0] tok_off;
    logic [SW-1:0]           off_ext;
    logic [AW-1:0]           src_diff;
    logic                    out_fire;
    logic                    ram_we;
    logic                    ram_re;
    logic [BYTE_W-1:0]       ram_rdata;
    logic [BYTE_W-1:0]       out_byte;
    logic                    stream_reset;

    // Take the next bit, shift it into the token and split off its offset field.
    assign bit_in    = r_sr[BYTE_W-1];
    assign left_dec  = r_left - 4'd1;
    assign tok_sh    = {r_tok[TBW-2:0], bit_in};
    assign cnt_inc   = r_cnt + TCW'(1);
    assign tok_off   = tok_sh[TOK_W-1 -: OFFSET_WIDTH];
    assign off_ext   = SW'(tok_off);
    // Another token completes in this word only after a 0 flag with enough bits left.
    assign tail_more = !r_sr[BYTE_W-2] && (32'(left_dec) > 32'(TOK_W));
    assign src_diff  = r_src - WSTART;

    assign out_fire  = (r_state == S_OUT) && i_out_ready;
    assign ram_we    = out_fire;
    assign ram_re    = (r_state == S_RD);
    assign out_byte  = r_is_copy ? (r_src_ok ? ram_rdata : SPACE_BYTE) : r_lit;

    // Parse one bit per cycle in the bit state and sequence the copy loop.
    always_comb begin
        n_state     = r_state;
        n_sr        = r_sr;
        n_left      = r_left;
        n_end       = r_end;
        n_kind      = r_kind;
        n_tok       = r_tok;
        n_cnt       = r_cnt;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_src       = r_src;
        n_copy      = r_copy;
        n_is_copy   = r_is_copy;
        n_src_ok    = r_src_ok;
        n_lit       = r_lit;
        n_tail_none = r_tail_none;
        stream_reset = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sr    = i_in_data.in_byte;
                    n_end   = i_in_data.stream_end;
                    n_left  = 4'(BYTE_W);
                    n_state = S_BITS;
                end
            end
            S_BITS: begin
                n_sr   = {r_sr[BYTE_W-2:0], 1'b0};
                n_left = left_dec;
                if (left_dec == 4'd0) begin
                    n_state = S_IDLE;
                    stream_reset = r_end;
                end
                case (r_kind)
                    K_FLAG: begin
                        n_kind = bit_in ? K_LIT : K_MATCH;
                        n_tok  = '0;
                        n_cnt  = '0;
                    end
                    K_LIT: begin
                        n_tok = tok_sh;
                        n_cnt = cnt_inc;
                        if (cnt_inc == TCW'(BYTE_W)) begin
                            n_lit        = tok_sh[BYTE_W-1:0];
                            n_is_copy    = 1'b0;
                            n_copy       = '0;
                            n_tail_none  = !tail_more;
                            n_kind       = K_FLAG;
                            n_cnt        = '0;
                            n_state      = S_OUT;
                            stream_reset = 1'b0;
                        end
                    end
                    K_MATCH: begin
                        n_tok = tok_sh;
                        n_cnt = cnt_inc;
                        if (cnt_inc == TCW'(TOK_W)) begin
                            n_src        = off_ext[AW-1:0];
                            n_copy       = CLW'(tok_sh[LENGTH_WIDTH-1:0]) + CLW'(MATCH_BIAS);
                            n_is_copy    = 1'b1;
                            n_tail_none  = !tail_more;
                            n_kind       = K_FLAG;
                            n_cnt        = '0;
                            n_state      = S_RD;
                            stream_reset = 1'b0;
                        end
                    end
                    default: begin
                        n_kind = K_FLAG;
                    end
                endcase
            end
            S_RD: begin
                // Entries not yet written in this stream read as spaces.
                n_src_ok = ({1'b0, src_diff} < r_fill);
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_wptr = r_wptr + AW'(1);
                    if (r_fill != FILL_FULL) begin
                        n_fill = r_fill + (AW+1)'(1);
                    end
                    if (r_copy != '0) begin
                        n_copy  = r_copy - CLW'(1);
                        n_src   = r_src + AW'(1);
                        n_state = S_RD;
                    end else if (r_left != 4'd0) begin
                        n_state = S_BITS;
                    end else begin
                        n_state = S_IDLE;
                        stream_reset = r_end;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Return the parser and window to the start of a stream.
        if (stream_reset) begin
            n_kind = K_FLAG;
            n_tok  = '0;
            n_cnt  = '0;
            n_wptr = WSTART;
            n_fill = '0;
        end
    end

    // Hold control state under reset, payload registers run free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_end   <= 1'b0;
            r_kind  <= K_FLAG;
            r_cnt   <= '0;
            r_wptr  <= WSTART;
            r_fill  <= '0;
            r_copy  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_end   <= n_end;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
            r_wptr  <= n_wptr;
            r_fill  <= n_fill;
            r_copy  <= n_copy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr        <= n_sr;
        r_tok       <= n_tok;
        r_src       <= n_src;
        r_is_copy   <= n_is_copy;
        r_src_ok    <= n_src_ok;
        r_lit       <= n_lit;
        r_tail_none <= n_tail_none;
    end

    // History window.
    lzsd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (out_byte),
        .i_re    (ram_re),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // Drive the handshake and output word.
    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = (r_state == S_OUT);
    assign o_out_data.out_byte = out_byte;
    assign o_out_data.run_last = r_tail_none && (r_copy == '0);

    `CHK_ALWAYS(a_fill_bound, r_fill <= FILL_FULL, "fill count beyond window size")
    `CHK_ALWAYS(a_sides_apart, !(o_in_ready && o_out_valid), "input ready while output valid")
    `CHK_NEXT(a_load_word, i_in_valid && o_in_ready, (r_state == S_BITS) && (r_left == 4'(BYTE_W)), "accepted word not loaded")
    `CHK_NEXT(a_last_idle, out_fire && o_out_data.run_last && (r_left == 4'd0), r_state == S_IDLE, "run end did not return to idle")

endmodule
